/* hdl/bss_pkg.sv */
// Shared types and constants for the binomial square sum block.
// Holds the controller/datapath command and status structs; no dependencies.
`timescale 1ns / 1ps

package bss_pkg;

  // Fixed field widths of the ports
  localparam int unsigned N_W   = 8;
  localparam int unsigned SUM_W = 64;
  // Divisor i+1 reaches 2^N_W
  localparam int unsigned DSR_W = N_W + 1;

  typedef struct packed {
    logic load;       // take a new n, restart coefficient and sum
    logic square;     // register coeff * coeff
    logic accum;      // add the square into the running sum
    logic div_start;  // start coeff * (n - i) / (i + 1)
    logic advance;    // take the quotient as the next coefficient
    logic publish;    // move the result into the output register
    logic ovf;        // overflow flag that goes with publish
  } bss_cmd_t;

  typedef struct packed {
    logic big_coeff;  // coefficient square surely exceeds the limit
    logic sq_ovf;     // registered square exceeds the limit
    logic sum_ovf;    // sum plus square exceeds the limit
    logic last;       // i has reached n
    logic div_busy;   // divider still iterating
    logic out_free;   // output register can take a result this cycle
  } bss_sts_t;

endpackage

/* hdl/bss_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses bss_pkg for the divisor width.
`timescale 1ns / 1ps

module bss_div #(
  parameter int unsigned DVD_W = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DVD_W-1:0]          dividend_i,
  input  logic [bss_pkg::DSR_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [DVD_W-1:0]          quotient_o
);
  import bss_pkg::*;

  localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DVD_W-1:0]   quo_q, quo_d;
  logic [DSR_W-1:0]   rem_q, rem_d;
  logic [DSR_W-1:0]   dsr_q;
  logic [DSR_W:0]     rem_sh;
  logic [DSR_W:0]     diff;
  logic               ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    ge     = rem_sh >= {1'b0, dsr_q};
    // remainder stays below the divisor, so it fits DSR_W bits
    rem_d  = ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    quo_d  = {quo_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/bss_datapath.sv */
// Datapath: coefficient, square and sum registers, limit checks, output register.
// Uses bss_pkg for command/status structs and instantiates bss_div.
`timescale 1ns / 1ps

module bss_datapath #(
  parameter int unsigned RESULT_WIDTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bss_pkg::bss_cmd_t         cmd_i,
  output bss_pkg::bss_sts_t         sts_o,
  input  logic [bss_pkg::N_W-1:0]   n_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [bss_pkg::SUM_W-1:0] sum_o,
  output logic                      overflow_o
);
  import bss_pkg::*;

  // A coefficient at or above 2^HALF has a square of at least 2^RESULT_WIDTH
  localparam int unsigned HALF   = (RESULT_WIDTH + 1) / 2;
  localparam int unsigned COEF_W = HALF + N_W;
  localparam int unsigned SQ_W   = 2 * HALF;
  localparam int unsigned W      = RESULT_WIDTH;

  logic [N_W-1:0]    n_q, i_q;
  logic [COEF_W-1:0] coeff_q;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [W-1:0]      sum_q;
  logic [W:0]        sq_ext, sum_ext;
  logic [HALF-1:0]   coeff_lo;
  logic [COEF_W-1:0] dividend;
  logic [DSR_W-1:0]  divisor;
  logic [COEF_W-1:0] quotient;
  logic              div_busy;
  logic              out_valid_q;
  logic [SUM_W-1:0]  sum_out_q;
  logic              ovf_out_q;

  assign coeff_lo = coeff_q[HALF-1:0];
  assign sq_d     = SQ_W'(coeff_lo) * SQ_W'(coeff_lo);
  assign sq_ext   = (W + 1)'(sq_q);
  assign sum_ext  = {1'b0, sum_q} + sq_ext;
  assign dividend = COEF_W'(coeff_lo) * COEF_W'(n_q - i_q);
  assign divisor  = {1'b0, i_q} + DSR_W'(1);

  bss_div #(
    .DVD_W(COEF_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .busy_o    (div_busy),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= n_i;
      i_q     <= '0;
      coeff_q <= COEF_W'(1);
      sum_q   <= '0;
    end else begin
      if (cmd_i.square) begin
        sq_q <= sq_d;
      end
      if (cmd_i.accum) begin
        sum_q <= sum_ext[W-1:0];
      end
      if (cmd_i.advance) begin
        coeff_q <= quotient;
        i_q     <= i_q + N_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      sum_out_q <= cmd_i.ovf ? '0 : SUM_W'(sum_q);
      ovf_out_q <= cmd_i.ovf;
    end
  end

  always_comb begin
    sts_o.big_coeff = |coeff_q[COEF_W-1:HALF];
    sts_o.sq_ovf    = sq_ext[W];
    sts_o.sum_ovf   = sum_ext[W];
    sts_o.last      = (i_q == n_q);
    sts_o.div_busy  = div_busy;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign sum_o       = sum_out_q;
  assign overflow_o  = ovf_out_q;

endmodule

/* hdl/bss_ctrl.sv */
// Controller state machine: sequences square, accumulate and divide per coefficient.
// Uses bss_pkg for command/status structs.
`timescale 1ns / 1ps

module bss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bss_pkg::bss_sts_t sts_i,
  output bss_pkg::bss_cmd_t cmd_o
);
  import bss_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   ovf_q;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SQUARE: begin
        cmd_o.square = !sts_i.big_coeff;
      end
      ST_ACCUM: begin
        if (!(sts_i.sq_ovf || sts_i.sum_ovf)) begin
          cmd_o.accum     = 1'b1;
          cmd_o.div_start = !sts_i.last;
        end
      end
      ST_DIVIDE: begin
        cmd_o.advance = !sts_i.div_busy;
      end
      ST_FINISH: begin
        cmd_o.publish = sts_i.out_free;
        cmd_o.ovf     = ovf_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovf_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            ovf_q   <= 1'b0;
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          // drop the rest of the row once a square cannot fit
          if (sts_i.big_coeff) begin
            ovf_q   <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (sts_i.sq_ovf || sts_i.sum_ovf) begin
            ovf_q   <= 1'b1;
            state_q <= ST_FINISH;
          end else if (sts_i.last) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (!sts_i.div_busy) begin
            state_q <= ST_SQUARE;
          end
        end
        ST_FINISH: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/binomial_square_sum_top.sv */
// Top level of the binomial square sum block: controller plus datapath.
// Uses bss_pkg and instantiates bss_ctrl and bss_datapath.
`timescale 1ns / 1ps

// For each n this block returns the sum of C(n,i)^2 over i = 0..n, that is
// C(2n,n), held to RESULT_WIDTH bits; when the true sum does not fit, sum is 0
// and overflow is 1. One transaction is worked at a time. Each coefficient
// is squared and accumulated, then the bit-serial divider forms the next
// coefficient; accepting n and posting the result come on top. At width 64
// the largest n whose sum fits is 33, with 34 coefficients. The result sits
// in an output register, so a new transaction is accepted while the previous
// result waits to be taken.
module binomial_square_sum_top #(
  parameter int unsigned RESULT_WIDTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bss_pkg::N_W-1:0]   n_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bss_pkg::SUM_W-1:0] sum_o,
  output logic                      overflow_o
);
  import bss_pkg::*;

  bss_cmd_t cmd;
  bss_sts_t sts;

  bss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bss_datapath #(
    .RESULT_WIDTH(RESULT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .n_i        (n_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .sum_o      (sum_o),
    .overflow_o (overflow_o)
  );

  a_ovf_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> sum_o == '0)
    else $error("overflow result carries a nonzero sum");

  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sum_o >> RESULT_WIDTH) == '0)
    else $error("sum exceeds the result width");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again before work finished");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !out_valid_o || out_ready_i)
    else $error("result posted over an untaken result");

endmodule
